// ----- rtl/core/sample_std_deviation_defines.svh -----
// assertion macros shared by the sample standard deviation rtl
`ifndef SAMPLE_STD_DEVIATION_DEFINES_SVH
`define SAMPLE_STD_DEVIATION_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SSD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sample_std_deviation: implication check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define SSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sample_std_deviation: next-cycle check failed");

`endif

// ----- rtl/core/ssd_pkg.sv -----
// types, widths and codes shared by the sample standard deviation modules
package ssd_pkg;

   localparam int MaxSamples  = 65536;
   localparam int SampleBits  = 24;
   localparam int SampleWidth = 24;
   localparam int CountBits   = $clog2(MaxSamples + 1);
   localparam int SumBits     = SampleBits + CountBits - 1;
   localparam int SqSumBits   = 64;
   localparam int AccBits     = 2 * SumBits;
   localparam int FracShift   = 16;
   localparam int DivBits     = AccBits + FracShift;
   localparam int DenBits     = 32;
   localparam int RadBits     = 62;
   localparam int RootBits    = 64;
   localparam int StdDevBits  = 31;
   localparam int StatusBits  = 2;

   localparam int MulASteps   = CountBits;
   localparam int MulBSteps   = SumBits;
   localparam int DivSteps    = DivBits;
   localparam int SqrtSteps   = RadBits / 2 + 1;
   localparam int StepCntBits = $clog2(DivSteps + 1);

   localparam logic [StatusBits-1:0] StatusOk        = 2'd0;
   localparam logic [StatusBits-1:0] StatusNoSamples = 2'd1;
   localparam logic [StatusBits-1:0] StatusOneSample = 2'd2;
   localparam logic [StatusBits-1:0] StatusOverflow  = 2'd3;

   localparam logic [StdDevBits-1:0] StdDevSat = {StdDevBits{1'b1}};

   typedef struct packed {
      logic acc_add;
      logic start;
      logic load_b;
      logic mul_step;
      logic mul_sub;
      logic div_load;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic few_samples;
   } stat_type;

endpackage

// ----- rtl/core/ssd_ctrl.sv -----
// sequencer for accumulate, multiply, divide, root and result handoff
module ssd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_action,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ssd_pkg::stat_type  stat,
   output ssd_pkg::cmd_type   cmd
);

   localparam logic [3:0] StIdle     = 4'd0;
   localparam logic [3:0] StMulA     = 4'd1;
   localparam logic [3:0] StLoadB    = 4'd2;
   localparam logic [3:0] StMulB     = 4'd3;
   localparam logic [3:0] StDivLoad  = 4'd4;
   localparam logic [3:0] StDiv      = 4'd5;
   localparam logic [3:0] StSqrtLoad = 4'd6;
   localparam logic [3:0] StSqrt     = 4'd7;
   localparam logic [3:0] StDone     = 4'd8;

   logic [3:0]                        state_ff, state_in;
   logic [ssd_pkg::StepCntBits-1:0]   step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              accept;
   logic [ssd_pkg::StepCntBits-1:0]   step_next;

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign step_next = step_ff + ssd_pkg::StepCntBits'(1);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         StIdle: begin
            step_in = '0;
            if (accept && !req_action) begin
               cmd.acc_add = 1'b1;
            end else if (accept) begin
               cmd.start = 1'b1;
               state_in  = stat.few_samples ? StDone : StMulA;
            end
         end
         StMulA: begin
            cmd.mul_step = 1'b1;
            step_in      = step_next;
            if (step_ff == ssd_pkg::StepCntBits'(ssd_pkg::MulASteps - 1)) begin
               step_in  = '0;
               state_in = StLoadB;
            end
         end
         StLoadB: begin
            cmd.load_b = 1'b1;
            state_in   = StMulB;
         end
         StMulB: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sub  = 1'b1;
            step_in      = step_next;
            if (step_ff == ssd_pkg::StepCntBits'(ssd_pkg::MulBSteps - 1)) begin
               step_in  = '0;
               state_in = StDivLoad;
            end
         end
         StDivLoad: begin
            cmd.div_load = 1'b1;
            state_in     = StDiv;
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            step_in      = step_next;
            if (step_ff == ssd_pkg::StepCntBits'(ssd_pkg::DivSteps - 1)) begin
               step_in  = '0;
               state_in = StSqrtLoad;
            end
         end
         StSqrtLoad: begin
            cmd.sqrt_load = 1'b1;
            state_in      = StSqrt;
         end
         StSqrt: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_next;
            if (step_ff == ssd_pkg::StepCntBits'(ssd_pkg::SqrtSteps - 1)) begin
               step_in  = '0;
               state_in = StDone;
            end
         end
         StDone: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/ssd_dp.sv -----
// accumulators, shift-add multiplier, restoring divider and bitwise root
module ssd_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ssd_pkg::cmd_type                      cmd,
   input  logic signed [ssd_pkg::SampleWidth-1:0] req_sample,
   output ssd_pkg::stat_type                     stat,
   output logic [ssd_pkg::StdDevBits-1:0]        rsp_std_dev,
   output logic [ssd_pkg::StatusBits-1:0]        rsp_status,
   output logic [ssd_pkg::CountBits-1:0]         rsp_sample_count
);

   localparam int SW = ssd_pkg::SampleWidth;
   localparam int CB = ssd_pkg::CountBits;
   localparam int SB = ssd_pkg::SumBits;
   localparam int QB = ssd_pkg::SqSumBits;
   localparam int AB = ssd_pkg::AccBits;
   localparam int DB = ssd_pkg::DivBits;
   localparam int NB = ssd_pkg::DenBits;
   localparam int RB = ssd_pkg::RadBits;
   localparam int TB = ssd_pkg::RootBits;
   localparam int OB = ssd_pkg::StdDevBits;

   // accumulated state
   logic [CB-1:0]        count_ff, count_in;
   logic signed [SB-1:0] sum_ff, sum_in;
   logic [QB-1:0]        sqsum_ff, sqsum_in;
   logic                 ovf_ff, ovf_in;

   // finish datapath
   logic [AB-1:0] acc_ff, acc_in;
   logic [AB-1:0] mcand_ff, mcand_in;
   logic [SB-1:0] mplier_ff, mplier_in;
   logic [DB-1:0] num_ff, num_in;
   logic [NB-1:0] rem_ff, rem_in;
   logic [NB-1:0] den_ff, den_in;
   logic [RB-1:0] rad_ff, rad_in;
   logic [TB-1:0] root_ff, root_in;
   logic [TB-1:0] rbit_ff, rbit_in;

   logic [OB-1:0]                  std_dev_ff;
   logic [ssd_pkg::StatusBits-1:0] status_ff;
   logic [CB-1:0]                  count_out_ff;

   logic signed [SW-1:0] x;
   logic [SW-1:0]        mag;
   logic [2*SW-1:0]      square;
   logic [SB-1:0]        smag;
   logic [2*CB-1:0]      den_full;
   logic [NB:0]          trial;
   logic [NB:0]          trial_diff;
   logic                 trial_ge;
   logic [TB:0]          root_sum;
   logic                 root_ge;
   logic                 few;
   logic                 sat;

   assign x      = SW'(signed'(req_sample[ssd_pkg::SampleBits-1:0]));
   assign mag    = x[SW-1] ? SW'(-x) : SW'(x);
   assign square = mag * mag;
   assign smag   = sum_ff[SB-1] ? SB'(-sum_ff) : SB'(sum_ff);

   assign den_full   = count_ff * (count_ff - CB'(1));
   assign trial      = {rem_ff, num_ff[DB-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign trial_ge   = (trial >= {1'b0, den_ff});

   assign root_sum = {1'b0, root_ff} + {1'b0, rbit_ff};
   assign root_ge  = ({{(TB + 1 - RB){1'b0}}, rad_ff} >= root_sum);

   assign few = (count_ff < CB'(2));
   assign sat = |num_ff[DB-1:RB];

   assign stat.few_samples = few;

   // sample accumulation, cleared by finish
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sqsum_in = sqsum_ff;
      ovf_in   = ovf_ff;
      if (cmd.finish) begin
         count_in = '0;
         sum_in   = '0;
         sqsum_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.acc_add) begin
         if (count_ff == CB'(ssd_pkg::MaxSamples)) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CB'(1);
            sum_in   = sum_ff + SB'(x);
            sqsum_in = sqsum_ff + QB'(square);
         end
      end
   end

   // n * s2 - s1 * s1, one multiplier bit a cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (cmd.start) begin
         acc_in    = '0;
         mcand_in  = AB'(sqsum_ff);
         mplier_in = SB'(count_ff);
      end else if (cmd.load_b) begin
         mcand_in  = AB'(smag);
         mplier_in = smag;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            acc_in = cmd.mul_sub ? (acc_ff - mcand_ff) : (acc_ff + mcand_ff);
         end
         mcand_in  = {mcand_ff[AB-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[SB-1:1]};
      end
   end

   // restoring division, quotient shifts into the numerator register
   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (cmd.div_load) begin
         num_in = {acc_ff, {ssd_pkg::FracShift{1'b0}}};
         rem_in = '0;
         den_in = den_full[NB-1:0];
      end else if (cmd.div_step) begin
         num_in = {num_ff[DB-2:0], trial_ge};
         rem_in = trial_ge ? trial_diff[NB-1:0] : trial[NB-1:0];
      end
   end

   // floor square root, two radicand bits a cycle
   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rbit_in = rbit_ff;
      if (cmd.sqrt_load) begin
         rad_in  = num_ff[RB-1:0];
         root_in = '0;
         rbit_in = TB'(1) << RB;
      end else if (cmd.sqrt_step) begin
         if (root_ge) begin
            rad_in  = rad_ff - root_sum[RB-1:0];
            root_in = (root_ff >> 1) + rbit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         rbit_in = rbit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sqsum_ff <= sqsum_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      rbit_ff   <= rbit_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         count_out_ff <= count_ff;
         if (count_ff == '0) begin
            std_dev_ff <= '0;
            status_ff  <= ssd_pkg::StatusNoSamples;
         end else if (few) begin
            std_dev_ff <= '0;
            status_ff  <= ssd_pkg::StatusOneSample;
         end else begin
            std_dev_ff <= sat ? ssd_pkg::StdDevSat : root_ff[OB-1:0];
            status_ff  <= ovf_ff ? ssd_pkg::StatusOverflow : ssd_pkg::StatusOk;
         end
      end
   end

   assign rsp_std_dev      = std_dev_ff;
   assign rsp_status       = status_ff;
   assign rsp_sample_count = count_out_ff;

endmodule

// ----- rtl/core/sample_std_deviation.sv -----
// top level of the sample standard deviation accumulator
// add beats: one per cycle while idle, no result; accumulate is one square, two adds and a count increment
// finish with two or more samples: the sequencer runs the serial multiply n * s2, load,
//   serial multiply s1 * s1, divider load, restoring divide, root load and root steps,
//   then the handoff state raises rsp_valid; no request beat is taken meanwhile
// finish with fewer than two samples: the sequencer goes straight to the handoff state
`include "sample_std_deviation_defines.svh"

module sample_std_deviation (
   input  logic                                   clock,
   input  logic                                   reset,
   // request beats: action 0 adds a sample, action 1 finishes
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_action,
   input  logic signed [ssd_pkg::SampleWidth-1:0] req_sample,
   // response beats, one per finish
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ssd_pkg::StdDevBits-1:0]         rsp_std_dev,
   output logic [ssd_pkg::StatusBits-1:0]         rsp_status,
   output logic [ssd_pkg::CountBits-1:0]          rsp_sample_count
);

   // reset (synchronous, active high) clears count, sums, overflow, sequencer and rsp_valid

   // command and status between sequencer and datapath
   ssd_pkg::cmd_type  cmd;
   ssd_pkg::stat_type stat;

   // sequencer: takes beats only when idle, holds rsp_valid
   ssd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: running sums, variance numerator, divide, root, result register
   ssd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .stat             (stat),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_status       (rsp_status),
      .rsp_sample_count (rsp_sample_count)
   );

   // a finish beat always takes the sequencer out of idle
   `SSD_ASSERT_NEXT(a_busy_after_finish, req_valid && req_ready && req_action, !req_ready)
   // a new response is only loaded from a busy sequencer
   `SSD_ASSERT_IMPLY(a_load_while_busy, $rose(rsp_valid), !$past(req_ready))
   // an empty finish reports nothing but the status
   `SSD_ASSERT_IMPLY(a_empty_result, rsp_valid && (rsp_status == ssd_pkg::StatusNoSamples), (rsp_std_dev == '0) && (rsp_sample_count == '0))

endmodule
